>>> sv/lz_history_window_assert.svh
// ----------------------------------------------------------------------------
// lz_history_window assertion macros
// Concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LZ_HISTORY_WINDOW_ASSERT_SVH
`define LZ_HISTORY_WINDOW_ASSERT_SVH

// Same-cycle implication.
`define LHW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LHW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lzhw_pkg.sv
// ----------------------------------------------------------------------------
// lzhw_pkg
// Item types and fixed field widths of the LZ history window.
// ----------------------------------------------------------------------------
package lzhw_pkg;

  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 13;
  localparam int LENGTH_W = 7;

  localparam logic MODE_LITERAL = 1'b0;
  localparam logic MODE_COPY    = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [BYTE_W-1:0]   literal_byte;
    logic [OFFSET_W-1:0] back_dist;
    logic [LENGTH_W-1:0] copy_length;
    logic                emit_output;
  } lzhw_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } lzhw_out_t;

endpackage

>>> sv/lz_history_window.sv
// ----------------------------------------------------------------------------
// lz_history_window
// Sliding history window of an LZ77-style decompressor.
// ----------------------------------------------------------------------------
// A literal item writes one byte at the write position and does not hold off
// the next item, nor does a copy of zero length. A copy item of L bytes (L
// saturated to MAX_COPY, L of one or more) holds off the next item until its
// last byte is written back, later if the result side stalls: the window is
// a single memory with one read and one write port, so one byte is read,
// written back at the write position and emitted per cycle unless stalled.
// A read that hits the byte being written in the same cycle (offset of one)
// is forwarded. The window holds no reset value and needs no clearing pass;
// only bytes already written may be referenced.
// ----------------------------------------------------------------------------
`include "lz_history_window_assert.svh"

module lz_history_window #(
  parameter int WINDOW_BYTES = 4096,
  parameter int MAX_COPY     = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzhw_pkg::lzhw_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output lzhw_pkg::lzhw_out_t out_item
);
  import lzhw_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);

  logic [BYTE_W-1:0] mem [WINDOW_BYTES];
  logic [BYTE_W-1:0] mem_q_r;

  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       rd_r, rd_nxt;
  logic [LENGTH_W-1:0] remain_r, remain_nxt;
  logic                emit_r, emit_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_last_r, s1_last_nxt;
  logic                fwd_r, fwd_nxt;
  logic [BYTE_W-1:0]   fwd_data_r, fwd_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  lzhw_out_t           out_item_r, out_item_nxt;

  logic                in_acc, lit_we, cp_start;
  logic                s1_adv, rd_issue, mem_we;
  logic [BYTE_W-1:0]   s1_byte, mem_wdata;
  logic [LENGTH_W-1:0] len_sat;
  logic [AW+OFFSET_W-1:0] start_diff;

  assign in_ready  = !s1_valid_r && (remain_r == '0);
  assign in_acc    = in_valid && in_ready;
  assign lit_we    = in_acc && (in_item.mode == MODE_LITERAL);
  assign cp_start  = in_acc && (in_item.mode == MODE_COPY);

  assign s1_byte   = fwd_r ? fwd_data_r : mem_q_r;
  assign s1_adv    = s1_valid_r && (!emit_r || !out_valid_r || out_ready);
  assign rd_issue  = (remain_r != '0) && (!s1_valid_r || s1_adv);

  assign mem_we    = lit_we || s1_adv;
  assign mem_wdata = lit_we ? in_item.literal_byte : s1_byte;

  assign len_sat = (in_item.copy_length > LENGTH_W'(MAX_COPY)) ?
                   LENGTH_W'(MAX_COPY) : in_item.copy_length;
  // start of copy, modulo the window size
  assign start_diff = {{OFFSET_W{1'b0}}, wp_r} - {{AW{1'b0}}, in_item.back_dist};

  always_comb begin
    wp_nxt        = mem_we ? wp_r + AW'(1) : wp_r;
    rd_nxt        = rd_r;
    remain_nxt    = remain_r;
    emit_nxt      = emit_r;
    s1_valid_nxt  = s1_valid_r;
    s1_last_nxt   = s1_last_r;
    fwd_nxt       = fwd_r;
    fwd_data_nxt  = fwd_data_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (cp_start) begin
      rd_nxt     = start_diff[AW-1:0];
      remain_nxt = len_sat;
      emit_nxt   = in_item.emit_output;
    end else if (rd_issue) begin
      rd_nxt     = rd_r + AW'(1);
      remain_nxt = remain_r - LENGTH_W'(1);
    end

    if (rd_issue) begin
      s1_valid_nxt = 1'b1;
      s1_last_nxt  = (remain_r == LENGTH_W'(1));
      // read hits the byte written this cycle: take it from the write side
      fwd_nxt      = s1_adv && (rd_r == wp_r);
      fwd_data_nxt = s1_byte;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    if (s1_adv && emit_r) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.out_byte = s1_byte;
      out_item_nxt.last     = s1_last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= mem_wdata;
    end
    if (rd_issue) begin
      mem_q_r <= mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      remain_r    <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      remain_r    <= remain_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r       <= rd_nxt;
    emit_r     <= emit_nxt;
    s1_last_r  <= s1_last_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LHW_ASSERT_IMPL(a_one_writer, clk, rst_n, lit_we, !s1_adv, "literal and copy write collide")
  `LHW_ASSERT_NEXT(a_emit_lands, clk, rst_n, s1_adv && emit_r, out_valid_r, "emitted byte lost")
  `LHW_ASSERT_IMPL(a_remain_cap, clk, rst_n, 1'b1, remain_r <= LENGTH_W'(MAX_COPY),
                   "copy count beyond limit")
  `LHW_ASSERT_NEXT(a_fwd_src, clk, rst_n, rd_issue && !s1_adv, !fwd_r, "forward without write")

endmodule

>>> tb/lz_history_window_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz_history_window_tb
// Self-checking bench for the LZ history window.
// A short table of literal and copy items runs first, then random traffic.
// Copies only reach bytes already written. Every emitted byte is compared with
// the table's expected byte or a shadow of the window kept in the bench. Both
// handshakes idle at random, with one long result stall and one full drain.
// ----------------------------------------------------------------------------
module lz_history_window_tb;
  import lzhw_pkg::*;

  localparam int WIN       = 4096;
  localparam int MAX_COPY  = 64;
  localparam int N_RANDOM  = 460;
  localparam int LIMIT     = 800000;
  localparam int MAX_PRINT = 100;

  typedef struct {
    lzhw_in_t    item;
    bit          typed;
    logic [7:0]  tbyte;
    int          tcount;
  } row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  lzhw_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lzhw_out_t out_item;

  // shadow of the window
  logic [7:0]  hist [WIN];
  bit          written [WIN];
  int          written_cnt = 0;
  logic [11:0] wpos = '0;

  lzhw_out_t pending_bytes [$];
  row_t      directed_rows [$];

  int   err_count  = 0;
  int   n_accepted = 0;
  int   cycles     = 0;
  logic calm       = 1'b0;
  logic out_hold   = 1'b0;

  lz_history_window #(
    .WINDOW_BYTES(WIN),
    .MAX_COPY    (MAX_COPY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINT) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic store_byte(input logic [7:0] b);
    hist[wpos] = b;
    if (!written[wpos]) begin
      written[wpos] = 1'b1;
      written_cnt++;
    end
    wpos = wpos + 12'd1;
  endtask

  // Apply one item to the shadow window; queue the bytes it emits if asked.
  task automatic advance_history(input lzhw_in_t it, input bit record);
    logic [11:0] rd;
    logic [7:0]  b;
    lzhw_out_t   r;
    int          n;
    if (it.mode == MODE_LITERAL) begin
      store_byte(it.literal_byte);
      return;
    end
    n  = (it.copy_length > 7'(MAX_COPY)) ? MAX_COPY : int'(it.copy_length);
    rd = wpos - it.back_dist[11:0];
    for (int i = 0; i < n; i++) begin
      b = hist[rd];
      store_byte(b);
      rd = rd + 12'd1;
      if (it.emit_output && record) begin
        r.out_byte = b;
        r.last     = (i == n - 1);
        pending_bytes.push_back(r);
      end
    end
  endtask

  // A copy is legal if every byte it reads was written before, either in
  // earlier items or earlier in the same copy.
  function automatic bit copy_is_safe(input logic [12:0] off, input logic [6:0] len);
    logic [11:0] rd;
    logic [11:0] pos;
    logic [11:0] d;
    int          n;
    n  = (len > 7'(MAX_COPY)) ? MAX_COPY : int'(len);
    rd = wpos - off[11:0];
    for (int i = 0; i < n; i++) begin
      pos = rd + 12'(i);
      d   = pos - wpos;
      if (!written[pos] && int'(d) >= i) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic lzhw_in_t rand_item();
    lzhw_in_t it;
    int       r;
    int       cap;
    it.mode         = ($urandom_range(99) < 35) ? MODE_LITERAL : MODE_COPY;
    it.literal_byte = 8'($urandom_range(255));
    it.back_dist    = 13'($urandom_range(8191));
    it.copy_length  = 7'($urandom_range(127));
    it.emit_output  = ($urandom_range(99) < 85);
    if (it.mode == MODE_LITERAL) return it;
    cap = (written_cnt > WIN) ? WIN : written_cnt;
    if (cap < 1) cap = 1;
    for (int tries = 0; tries < 8; tries++) begin
      r = $urandom_range(99);
      if (r < 5)       it.copy_length = 7'd0;
      else if (r < 15) it.copy_length = 7'($urandom_range(127, 65));
      else if (r < 55) it.copy_length = 7'($urandom_range(8, 1));
      else             it.copy_length = 7'($urandom_range(64, 1));
      r = $urandom_range(99);
      if (r < 5)       it.back_dist = 13'd0;
      else if (r < 13) it.back_dist = 13'($urandom_range(8191, 4096));
      else if (r < 45) it.back_dist = 13'($urandom_range(16, 1));
      else             it.back_dist = 13'($urandom_range(cap, 1));
      if (copy_is_safe(it.back_dist, it.copy_length)) return it;
    end
    // fall back on repeating the last byte written
    it.back_dist = 13'd1;
    return it;
  endfunction

  function automatic row_t mk(input logic mode, input int lit, input int off,
                              input int len, input bit emit, input bit typed,
                              input int tbyte, input int tcount);
    row_t r;
    r.item.mode         = mode;
    r.item.literal_byte = 8'(lit);
    r.item.back_dist    = 13'(off);
    r.item.copy_length  = 7'(len);
    r.item.emit_output  = emit;
    r.typed             = typed;
    r.tbyte             = 8'(tbyte);
    r.tcount            = tcount;
    return r;
  endfunction

  // Offer one item and hold it until accepted.
  task automatic offer(input lzhw_in_t it);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    n_accepted++;
  endtask

  task automatic send_row(input row_t row);
    lzhw_out_t r;
    offer(row.item);
    if (row.typed) begin
      for (int k = 0; k < row.tcount; k++) begin
        r.out_byte = row.tbyte;
        r.last     = (k == row.tcount - 1);
        pending_bytes.push_back(r);
      end
      advance_history(row.item, 1'b0);
    end else begin
      advance_history(row.item, 1'b1);
    end
  endtask

  // result side: random idling, one long hold-off
  always @(posedge clk) begin
    if (out_hold)  out_ready <= 1'b0;
    else if (calm) out_ready <= 1'b1;
    else           out_ready <= ($urandom_range(99) >= 7);
  end

  initial begin
    wait (n_accepted >= 120);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (400) @(posedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin
    lzhw_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_item.out_byte, out_item.last));
      end else begin
        want = pending_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    out_item.out_byte, want.out_byte));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_item.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("** lz_history_window: FAILED **");
      $finish;
    end
  end

  initial begin
    row_t row;
    int   guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    //                        mode          lit    off   len emit typed byte  n
    directed_rows.push_back(mk(MODE_LITERAL, 8'h00, 0,    0,  0, 1, 8'h00, 0));
    directed_rows.push_back(mk(MODE_LITERAL, 8'hFF, 0,    0,  0, 1, 8'h00, 0));
    // overlapping copy repeats the last byte
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 1,    4,  1, 1, 8'hFF, 4));
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 6,    1,  1, 1, 8'h00, 1));
    directed_rows.push_back(mk(MODE_LITERAL, 8'hA5, 0,    0,  0, 1, 8'h00, 0));
    directed_rows.push_back(mk(MODE_LITERAL, 8'h5A, 0,    0,  0, 1, 8'h00, 0));
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 2,    8,  1, 0, 8'h00, 0));
    // zero length
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 1,    0,  1, 1, 8'h00, 0));
    // output disabled, longest copy
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 3,    64, 0, 1, 8'h00, 0));
    // length saturates
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 1,    127, 1, 0, 8'h00, 0));
    directed_rows.push_back(mk(MODE_COPY,    8'hFF, 1,    64, 1, 0, 8'h00, 0));
    // literal ignores the copy fields
    directed_rows.push_back(mk(MODE_LITERAL, 8'h3C, 8191, 127, 1, 1, 8'h00, 0));
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 1,    1,  1, 1, 8'h3C, 1));
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 20,   20, 1, 0, 8'h00, 0));
    directed_rows.push_back(mk(MODE_COPY,    8'h00, 200,  64, 1, 0, 8'h00, 0));
    foreach (directed_rows[k]) send_row(directed_rows[k]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 180) calm <= 1'b1;
      if (i == 260) calm <= 1'b0;
      if (i == 330) begin
        // drop valid and drain every outstanding byte
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
      end
      row.item  = rand_item();
      row.typed = 1'b0;
      send_row(row);
    end

    // fill the ring so that wrapping offsets are legal
    while (written_cnt < WIN) begin
      send_row(mk(MODE_COPY, 8'h00, 1, 64, 0, 0, 8'h00, 0));
    end
    // offset zero and offsets at or beyond the window size
    send_row(mk(MODE_COPY, 8'h00, 0,    64, 1, 0, 8'h00, 0));
    send_row(mk(MODE_COPY, 8'h00, 4096, 7,  1, 0, 8'h00, 0));
    send_row(mk(MODE_COPY, 8'h00, 8191, 64, 1, 0, 8'h00, 0));
    send_row(mk(MODE_COPY, 8'h00, 4097, 1,  1, 0, 8'h00, 0));
    in_valid <= 1'b0;

    guard = 0;
    while (pending_bytes.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never emitted", pending_bytes.size()));

    if (err_count == 0) begin
      $display("** lz_history_window: PASSED **");
    end else begin
      $display("** lz_history_window: FAILED **");
    end
    $finish;
  end

endmodule
